>>> rtl/xypc_pkg.sv
// Shared types and constants for the XY position cascade controller.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package xypc_pkg;

  // Data path widths
  localparam int DATA_WIDTH = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int ERR_W      = DATA_WIDTH + 1;           // saturated speed error
  localparam int DX_W       = DATA_WIDTH + 2;           // error difference, mult operand
  localparam int PROD_W     = GAIN_W + 1 + DX_W;        // signed gain x operand
  localparam int SUM_W      = PROD_W + 1;               // sum of two products
  localparam int RND_SH     = 12;                       // Q4.12 gain scaling
  localparam int RND_W      = SUM_W - RND_SH;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  // Register reset values
  localparam logic [GAIN_W-1:0] POS_GAIN_X_RST   = GAIN_W'(262);
  localparam logic [GAIN_W-1:0] POS_GAIN_Y_RST   = GAIN_W'(496);
  localparam logic [GAIN_W-1:0] VEL_P_GAIN_X_RST = GAIN_W'(5734);
  localparam logic [GAIN_W-1:0] VEL_D_GAIN_X_RST = GAIN_W'(9011);
  localparam logic [LIM_W-1:0]  SPEED_LIMIT_RST  = LIM_W'(1280);
  localparam logic [LIM_W-1:0]  ROLL_LIMIT_RST   = LIM_W'(1536);
  localparam logic [LIM_W-1:0]  PITCH_LIMIT_RST  = LIM_W'(1280);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_GAIN_X   = 3'd0,
    REG_POS_GAIN_Y   = 3'd1,
    REG_VEL_P_GAIN_X = 3'd2,
    REG_VEL_D_GAIN_X = 3'd3,
    REG_SPEED_LIMIT  = 3'd4,
    REG_ROLL_LIMIT   = 3'd5,
    REG_PITCH_LIMIT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] pos_gain_x;
    logic [GAIN_W-1:0] pos_gain_y;
    logic [GAIN_W-1:0] vel_p_gain_x;
    logic [GAIN_W-1:0] vel_d_gain_x;
    logic [LIM_W-1:0]  speed_limit;
    logic [LIM_W-1:0]  roll_limit;
    logic [LIM_W-1:0]  pitch_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] speed_x;
    logic signed [DATA_WIDTH-1:0] speed_y;
  } in_data_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] roll_angle;
    logic signed [DATA_WIDTH-1:0] pitch_angle;
  } out_data_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MSEL_PX = 2'd0,   // pos_gain_x * -pos_x
    MSEL_PY = 2'd1,   // pos_gain_y * -pos_y
    MSEL_EX = 2'd2,   // vel_p_gain_x * err_x
    MSEL_DX = 2'd3    // vel_d_gain_x * (err_x - prev)
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     capture_x;
    logic     capture_y;
    logic     acc_load;
    logic     finish;
  } dp_cmd_t;

endpackage

>>> rtl/xypc_cfg_regs.sv
// Configuration register file: gains and limits, written by index.
// Depends on xypc_pkg.
`timescale 1ns / 1ps

module xypc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [xypc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xypc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output xypc_pkg::cfg_t                    cfg
);

  xypc_pkg::cfg_t cfg_r;

  // Index write; an unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_gain_x   <= xypc_pkg::POS_GAIN_X_RST;
      cfg_r.pos_gain_y   <= xypc_pkg::POS_GAIN_Y_RST;
      cfg_r.vel_p_gain_x <= xypc_pkg::VEL_P_GAIN_X_RST;
      cfg_r.vel_d_gain_x <= xypc_pkg::VEL_D_GAIN_X_RST;
      cfg_r.speed_limit  <= xypc_pkg::SPEED_LIMIT_RST;
      cfg_r.roll_limit   <= xypc_pkg::ROLL_LIMIT_RST;
      cfg_r.pitch_limit  <= xypc_pkg::PITCH_LIMIT_RST;
    end else if (cfg_we) begin
      case (xypc_pkg::cfg_reg_t'(cfg_index))
        xypc_pkg::REG_POS_GAIN_X:   cfg_r.pos_gain_x   <= cfg_wdata;
        xypc_pkg::REG_POS_GAIN_Y:   cfg_r.pos_gain_y   <= cfg_wdata;
        xypc_pkg::REG_VEL_P_GAIN_X: cfg_r.vel_p_gain_x <= cfg_wdata;
        xypc_pkg::REG_VEL_D_GAIN_X: cfg_r.vel_d_gain_x <= cfg_wdata;
        xypc_pkg::REG_SPEED_LIMIT:  cfg_r.speed_limit  <= cfg_wdata[xypc_pkg::LIM_W-1:0];
        xypc_pkg::REG_ROLL_LIMIT:   cfg_r.roll_limit   <= cfg_wdata[xypc_pkg::LIM_W-1:0];
        xypc_pkg::REG_PITCH_LIMIT:  cfg_r.pitch_limit  <= cfg_wdata[xypc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/xypc_datapath.sv
// Datapath: input capture, one shared signed multiplier, rounding, clamps,
// stored X speed error and the result register. Depends on xypc_pkg.
`timescale 1ns / 1ps

module xypc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  xypc_pkg::cfg_t      cfg,
  input  xypc_pkg::dp_cmd_t   cmd,
  input  xypc_pkg::in_data_t  in_data,
  output xypc_pkg::out_data_t out_data
);

  localparam int DW = xypc_pkg::DATA_WIDTH;
  localparam int EW = xypc_pkg::ERR_W;
  localparam int XW = xypc_pkg::DX_W;
  localparam int PW = xypc_pkg::PROD_W;
  localparam int SW = xypc_pkg::SUM_W;
  localparam int RW = xypc_pkg::RND_W;
  localparam int LW = xypc_pkg::LIM_W;
  localparam int GW = xypc_pkg::GAIN_W;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (xypc_pkg::RND_SH - 1);
  localparam logic signed [XW-1:0] ERR_HI   = XW'((64'd1 << DW) - 64'd1);
  localparam logic signed [XW-1:0] ERR_LO   = -ERR_HI - XW'(1);

  // Round to nearest, ties up, drop the Q.12 fraction
  function automatic logic signed [RW-1:0] rnd_q12(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    t = x + RND_HALF;
    return t[SW-1:xypc_pkg::RND_SH];
  endfunction

  // Symmetric clamp to +-lim
  function automatic logic signed [DW-1:0] clamp_sym(input logic signed [SW-1:0] v,
                                                     input logic [LW-1:0] lim);
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] r;
    l = $signed({{(SW-LW){1'b0}}, lim});
    if (v > l) r = l;
    else if (v < -l) r = -l;
    else r = v;
    return r[DW-1:0];
  endfunction

  // Saturate speed error to EW bits
  function automatic logic signed [EW-1:0] sat_err(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > ERR_HI) r = ERR_HI;
    else if (v < ERR_LO) r = ERR_LO;
    else r = v;
    return r[EW-1:0];
  endfunction

  xypc_pkg::in_data_t    in_r;
  xypc_pkg::out_data_t   out_r;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [PW-1:0]  acc_r;
  logic signed [EW-1:0]  ex_r, ex_nxt;
  logic signed [EW-1:0]  prev_r;
  logic signed [XW-1:0]  dx_r, dx_nxt;
  logic signed [DW-1:0]  pitch_r, pitch_nxt;
  logic signed [DW-1:0]  roll_nxt;
  logic [GW-1:0]         mul_a;
  logic signed [XW-1:0]  mul_b;
  logic signed [DW-1:0]  tgt_speed;
  logic signed [XW-1:0]  speed_diff_x, speed_diff_y;
  logic signed [EW-1:0]  ey;
  logic signed [XW-1:0]  neg_ey;
  logic signed [SW-1:0]  roll_sum;

  // Shared multiplier operand mux
  always_comb begin
    case (cmd.mul_sel)
      xypc_pkg::MSEL_PX: begin
        mul_a = cfg.pos_gain_x;
        mul_b = -XW'(in_r.pos_x);
      end
      xypc_pkg::MSEL_PY: begin
        mul_a = cfg.pos_gain_y;
        mul_b = -XW'(in_r.pos_y);
      end
      xypc_pkg::MSEL_EX: begin
        mul_a = cfg.vel_p_gain_x;
        mul_b = XW'(ex_r);
      end
      default: begin
        mul_a = cfg.vel_d_gain_x;
        mul_b = dx_r;
      end
    endcase
    prod_nxt = $signed({1'b0, mul_a}) * mul_b;
  end

  // Outer loop target speed from the last product; the X and Y captures use it in turn
  assign tgt_speed = clamp_sym(SW'(rnd_q12(SW'(prod_r))), cfg.speed_limit);

  // X speed error and its change against the stored error
  assign speed_diff_x = XW'(tgt_speed) - XW'(in_r.speed_x);
  assign ex_nxt       = sat_err(speed_diff_x);
  assign dx_nxt       = XW'(ex_nxt) - XW'(prev_r);

  // Y inner loop: unit gain, negated
  assign speed_diff_y = XW'(tgt_speed) - XW'(in_r.speed_y);
  assign ey           = sat_err(speed_diff_y);
  assign neg_ey       = -XW'(ey);
  assign pitch_nxt    = clamp_sym(SW'(neg_ey), cfg.pitch_limit);

  // X inner PD sum, rounded once
  assign roll_sum = SW'(acc_r) + SW'(prod_r);
  assign roll_nxt = clamp_sym(SW'(rnd_q12(roll_sum)), cfg.roll_limit);

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load)      in_r    <= in_data;
    if (cmd.capture_x) begin
      ex_r <= ex_nxt;
      dx_r <= dx_nxt;
    end
    if (cmd.capture_y) pitch_r <= pitch_nxt;
    if (cmd.acc_load)  acc_r   <= prod_r;
    if (cmd.finish) begin
      out_r.roll_angle  <= roll_nxt;
      out_r.pitch_angle <= pitch_r;
    end
  end

  // Stored X error carries across transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.finish) begin
      prev_r <= ex_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/xypc_ctrl.sv
// Controller: sequences the shared multiplier over four products and owns
// both channel handshakes. Depends on xypc_pkg.
`timescale 1ns / 1ps

module xypc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output xypc_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_MP,
    S_MD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = xypc_pkg::MSEL_PX;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_sel = xypc_pkg::MSEL_PX;
        state_nxt   = S_MY;
      end
      S_MY: begin
        cmd.mul_sel   = xypc_pkg::MSEL_PY;
        cmd.capture_x = 1'b1;
        state_nxt     = S_MP;
      end
      S_MP: begin
        cmd.mul_sel   = xypc_pkg::MSEL_EX;
        cmd.capture_y = 1'b1;
        state_nxt     = S_MD;
      end
      S_MD: begin
        cmd.mul_sel  = xypc_pkg::MSEL_DX;
        cmd.acc_load = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        cmd.mul_sel = xypc_pkg::MSEL_DX;
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Accepted transaction reaches the accumulate step through S_MX, S_MY and S_MP
  a_acc_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##4 cmd.acc_load)
    else $error("accumulate step out of sequence");

  // Result is written only after the accumulate step or while waiting on the sink
  a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> ($past(state_r) == S_MD || $past(state_r) == S_FIN))
    else $error("result written out of sequence");

  // A written result is presented next cycle
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result lost after write");

  // Never overwrite a result that is held by the sink
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.capture_x, cmd.capture_y, cmd.acc_load, cmd.finish}))
    else $error("overlapping datapath steps");

endmodule

>>> rtl/xy_position_cascade_controller_top.sv
// Top level of the XY position cascade controller.
// Instantiates xypc_cfg_regs, xypc_ctrl and xypc_datapath; depends on xypc_pkg.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid / in_stall / in_data) takes one sample of X/Y
//   position and velocity per transaction; output channel (out_valid /
//   out_stall / out_data) returns one roll/pitch pair per sample, in order.
// - Configuration: cfg_we with cfg_index and cfg_wdata writes one gain or
//   limit register in the cycle it is high; write only while the block is idle.
// - out_valid is registered and rises once the final step writes the result.
// - A new sample is taken only when idle. The single 17x18 multiplier is used
//   for four products per sample (two outer loop gains, the inner P and D
//   gains), then a final step rounds, clamps and writes the result register.
// - A result waiting in the output register does not block the next input;
//   if the sink still stalls when the next result is ready, the block holds
//   in its final step until the register frees, with in_stall high.
// - Reset (rst_n low, synchronous) restores the register reset values, clears
//   the stored X speed error and drops any pending result.
module xy_position_cascade_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  xypc_pkg::in_data_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output xypc_pkg::out_data_t               out_data,
  input  logic                              cfg_we,
  input  logic [xypc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xypc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  xypc_pkg::cfg_t    cfg;
  xypc_pkg::dp_cmd_t cmd;

  xypc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  xypc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  xypc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

>>> tb/tb_xy_position_cascade_controller_top.sv
// Testbench for xy_position_cascade_controller_top: directed table, then random
// configuration phases checked against a roll/pitch predictor. Depends on xypc_pkg.
`timescale 1ns / 1ps

module tb_xy_position_cascade_controller_top;

  localparam int NUM_REGS        = 7;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int WD_LIMIT        = 2000;
  localparam int DW              = xypc_pkg::DATA_WIDTH;
  localparam int GW              = xypc_pkg::GAIN_W;
  localparam int LW              = xypc_pkg::LIM_W;
  localparam int CW              = xypc_pkg::CFG_DATA_W;
  localparam logic [xypc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // past the last register

  localparam logic signed [DW-1:0] S_MIN = 16'sh8000;
  localparam logic signed [DW-1:0] S_MAX = 16'sh7FFF;
  localparam longint ERR_HI = (longint'(1) <<< (xypc_pkg::ERR_W - 1)) - 1;
  localparam longint ERR_LO = -(longint'(1) <<< (xypc_pkg::ERR_W - 1));

  typedef struct packed {
    logic                known;
    xypc_pkg::out_data_t att;
  } hand_att_t;

  typedef struct packed {
    xypc_pkg::in_data_t  stim;
    logic                known;
    xypc_pkg::out_data_t att;
  } dir_row_t;

  localparam int DIR_ROWS_N = 20;
  // X/Y samples at the reset gains; hand values only where the X loop stays at zero
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0},             1'b1, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, S_MAX},              1'b1, '{16'sd0, 16'sd1280}},
    '{'{16'sd0, 16'sd0, 16'sd0, S_MIN},              1'b1, '{16'sd0, -16'sd1280}},
    '{'{16'sd0, S_MAX, 16'sd0, 16'sd0},              1'b1, '{16'sd0, 16'sd1280}},
    '{'{16'sd0, S_MIN, 16'sd0, 16'sd0},              1'b1, '{16'sd0, -16'sd1280}},
    '{'{S_MIN, 16'sd0, 16'sd0, 16'sd0},              1'b0, '{16'sd0, 16'sd0}},
    '{'{S_MAX, 16'sd0, 16'sd0, 16'sd0},              1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, S_MAX, 16'sd0},              1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, S_MIN, 16'sd0},              1'b0, '{16'sd0, 16'sd0}},
    '{'{S_MIN, 16'sd0, S_MIN, 16'sd0},               1'b0, '{16'sd0, 16'sd0}},
    '{'{S_MAX, 16'sd0, S_MAX, 16'sd0},               1'b0, '{16'sd0, 16'sd0}},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1},         1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1},             1'b0, '{16'sd0, 16'sd0}},
    '{'{S_MAX, S_MAX, S_MAX, S_MAX},                 1'b0, '{16'sd0, 16'sd0}},
    '{'{S_MIN, S_MIN, S_MIN, S_MIN},                 1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd1000, -16'sd1000, 16'sd50, -16'sd50},   1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd1000, -16'sd1000, 16'sd50, -16'sd50},   1'b0, '{16'sd0, 16'sd0}},
    '{'{-16'sd1000, 16'sd1000, -16'sd50, 16'sd50},   1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd256, 16'sd0, 16'sd0, 16'sd1280},        1'b0, '{16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0},             1'b0, '{16'sd0, 16'sd0}}
  };

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  xypc_pkg::in_data_t                  in_data = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  xypc_pkg::out_data_t                 out_data;
  logic                                cfg_we = 1'b0;
  logic [xypc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CW-1:0]                       cfg_wdata = '0;

  // Predictor state: register copy and stored X speed error
  xypc_pkg::cfg_t ctl_cfg = '{xypc_pkg::POS_GAIN_X_RST, xypc_pkg::POS_GAIN_Y_RST,
                              xypc_pkg::VEL_P_GAIN_X_RST, xypc_pkg::VEL_D_GAIN_X_RST,
                              xypc_pkg::SPEED_LIMIT_RST, xypc_pkg::ROLL_LIMIT_RST,
                              xypc_pkg::PITCH_LIMIT_RST};
  longint prev_err_x = 0;

  xypc_pkg::out_data_t attitude_q [$];   // expected roll/pitch, oldest first
  hand_att_t hand_att_q [$];   // hand-entered values, one per offered transaction
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        src_idle = 1'b1;
  logic      sink_idle_en = 1'b1;
  int        hold_req = 0;

  xy_position_cascade_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock and one reset pulse
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Q.20 back to Q7.8: add half, floor shift
  function automatic longint rnd_q12(longint x);
    return (x + 2048) >>> xypc_pkg::RND_SH;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint sat_speed_err(longint v);
    if (v > ERR_HI) return ERR_HI;
    if (v < ERR_LO) return ERR_LO;
    return v;
  endfunction

  // Outer P loops, X inner PD, Y inner unit negated; updates the stored X error
  function automatic xypc_pkg::out_data_t predict_attitude(xypc_pkg::in_data_t s);
    longint              tgt_x, tgt_y, err_x, err_y, roll, pitch;
    xypc_pkg::out_data_t r;
    tgt_x = clamp_sym(rnd_q12(longint'(ctl_cfg.pos_gain_x) * -longint'(s.pos_x)),
                      longint'(ctl_cfg.speed_limit));
    tgt_y = clamp_sym(rnd_q12(longint'(ctl_cfg.pos_gain_y) * -longint'(s.pos_y)),
                      longint'(ctl_cfg.speed_limit));
    err_x = sat_speed_err(tgt_x - longint'(s.speed_x));
    err_y = sat_speed_err(tgt_y - longint'(s.speed_y));
    roll  = rnd_q12(longint'(ctl_cfg.vel_p_gain_x) * err_x +
                    longint'(ctl_cfg.vel_d_gain_x) * (err_x - prev_err_x));
    roll  = clamp_sym(roll, longint'(ctl_cfg.roll_limit));
    pitch = clamp_sym(-err_y, longint'(ctl_cfg.pitch_limit));
    prev_err_x    = err_x;
    r.roll_angle  = roll[DW-1:0];
    r.pitch_angle = pitch[DW-1:0];
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_field();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return S_MIN;
          1: return S_MAX;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      1, 2, 3, 4: return 16'(int'($urandom_range(4000)) - 2000);
      5, 6: return 16'(int'($urandom_range(24000)) - 12000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GW-1:0] rand_gain();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return GW'($urandom);
    endcase
  endfunction

  function automatic logic [LW-1:0] rand_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return LW'($urandom);
    endcase
  endfunction

  // All seven registers, limits with a random bit above their width, then a stray index
  task automatic program_regs(input xypc_pkg::cfg_t c);
    logic [CW-1:0] vals [NUM_REGS];
    vals[xypc_pkg::REG_POS_GAIN_X]   = c.pos_gain_x;
    vals[xypc_pkg::REG_POS_GAIN_Y]   = c.pos_gain_y;
    vals[xypc_pkg::REG_VEL_P_GAIN_X] = c.vel_p_gain_x;
    vals[xypc_pkg::REG_VEL_D_GAIN_X] = c.vel_d_gain_x;
    vals[xypc_pkg::REG_SPEED_LIMIT]  = {1'($urandom_range(1)), c.speed_limit};
    vals[xypc_pkg::REG_ROLL_LIMIT]   = {1'($urandom_range(1)), c.roll_limit};
    vals[xypc_pkg::REG_PITCH_LIMIT]  = {1'($urandom_range(1)), c.pitch_limit};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= xypc_pkg::cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_index <= REG_UNUSED;
    cfg_wdata <= CW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample, with random source gaps while src_idle is set, until taken
  task automatic send_sample(input xypc_pkg::in_data_t s, input hand_att_t h);
    hand_att_q.push_back(h);
    while (src_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // One edge first so the last accepted transaction is already queued
  task automatic wait_idle();
    @(posedge clk);
    while (attitude_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    xypc_pkg::cfg_t     c;
    xypc_pkg::in_data_t s;
    while (!rst_n) @(posedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++)
      send_sample(DIR_ROWS[i].stim, '{DIR_ROWS[i].known, DIR_ROWS[i].att});
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      c = '{rand_gain(), rand_gain(), rand_gain(), rand_gain(),
            rand_limit(), rand_limit(), rand_limit()};
      case (p)
        0: c = '{xypc_pkg::POS_GAIN_X_RST, xypc_pkg::POS_GAIN_Y_RST,
                 xypc_pkg::VEL_P_GAIN_X_RST, xypc_pkg::VEL_D_GAIN_X_RST,
                 xypc_pkg::SPEED_LIMIT_RST, xypc_pkg::ROLL_LIMIT_RST,
                 xypc_pkg::PITCH_LIMIT_RST};
        1: c = '1;
        2: c = '0;
        6: begin
          // gentle outer loop, wide limits: clamps rarely hit
          c.pos_gain_x  = GW'($urandom_range(4096));
          c.pos_gain_y  = GW'($urandom_range(4096));
          c.speed_limit = '1;
          c.roll_limit  = '1;
          c.pitch_limit = '1;
        end
        default: ;
      endcase
      program_regs(c);

      // phase 4 fills the block against a held sink; phase 5 runs with no gaps
      src_idle = (p != 4) && (p != 5);
      sink_idle_en <= (p != 5);
      if (p == 4) hold_req <= hold_req + 1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        s.pos_x   = rand_field();
        s.pos_y   = rand_field();
        s.speed_x = rand_field();
        s.speed_y = rand_field();
        send_sample(s, '0);
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result sink: random stall, one long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= sink_idle_en && ($urandom_range(99) < 35);
    end
  end

  // Register copy and expected results, updated at each write and input transaction
  always @(posedge clk) begin
    hand_att_t           h;
    xypc_pkg::out_data_t pred;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          xypc_pkg::REG_POS_GAIN_X:   ctl_cfg.pos_gain_x   = cfg_wdata;
          xypc_pkg::REG_POS_GAIN_Y:   ctl_cfg.pos_gain_y   = cfg_wdata;
          xypc_pkg::REG_VEL_P_GAIN_X: ctl_cfg.vel_p_gain_x = cfg_wdata;
          xypc_pkg::REG_VEL_D_GAIN_X: ctl_cfg.vel_d_gain_x = cfg_wdata;
          xypc_pkg::REG_SPEED_LIMIT:  ctl_cfg.speed_limit  = cfg_wdata[LW-1:0];
          xypc_pkg::REG_ROLL_LIMIT:   ctl_cfg.roll_limit   = cfg_wdata[LW-1:0];
          xypc_pkg::REG_PITCH_LIMIT:  ctl_cfg.pitch_limit  = cfg_wdata[LW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pred = predict_attitude(in_data);
        h = hand_att_q.pop_front();
        attitude_q.push_back(h.known ? h.att : pred);
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    xypc_pkg::out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (attitude_q.size() == 0) begin
        $error("out_data: unexpected transaction roll %0d pitch %0d",
               out_data.roll_angle, out_data.pitch_angle);
        mismatches++;
      end else begin
        want = attitude_q.pop_front();
        if (out_data.roll_angle !== want.roll_angle) begin
          $error("roll_angle: expected %0d, got %0d", want.roll_angle, out_data.roll_angle);
          mismatches++;
        end
        if (out_data.pitch_angle !== want.pitch_angle) begin
          $error("pitch_angle: expected %0d, got %0d", want.pitch_angle, out_data.pitch_angle);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/xypc_pkg.sv
rtl/xypc_cfg_regs.sv
rtl/xypc_datapath.sv
rtl/xypc_ctrl.sv
rtl/xy_position_cascade_controller_top.sv
tb/tb_xy_position_cascade_controller_top.sv
